[hdl/cnf_pkg.sv]
// Shared types, constants and the clause test for the CNF formula evaluator.
package cnf_pkg;

    localparam int SLOTS_PER_CLAUSE = 3;
    localparam int MAX_CLAUSES      = 64;
    localparam int MAX_ATOMS        = 64;

    localparam int ATOM_W   = 6;
    localparam int CIDX_W   = 6;
    localparam int SIDX_W   = 3;
    localparam int CFG_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int MASK_W   = 64;
    localparam int SLOT_W   = (SLOTS_PER_CLAUSE > 1) ? $clog2(SLOTS_PER_CLAUSE) : 1;
    localparam int STEP_W   = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_t;

    typedef struct packed {
        logic              present;
        logic              negated;
        logic [ATOM_W-1:0] atom;
    } slot_t;

    typedef slot_t [SLOTS_PER_CLAUSE-1:0] clause_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic in_use;
    } eval_ctrl_t;

    // OR of the literals in slot order, stopping at the first empty slot
    function automatic logic clause_holds(clause_t cl, logic [MASK_W-1:0] asg);
        logic value;
        logic alive;
        value = 1'b0;
        alive = 1'b1;
        for (int s = 0; s < SLOTS_PER_CLAUSE; s++) begin
            if (!cl[s].present) begin
                alive = 1'b0;
            end
            if (alive) begin
                value = value | (asg[cl[s].atom] ^ cl[s].negated);
            end
        end
        return value;
    endfunction

endpackage

[hdl/cnf_clause_cell.sv]
// One clause cell of the rotating clause ring.
module cnf_clause_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  cnf_pkg::clause_t              shift_in,
    input  logic                          load_en,
    input  logic [cnf_pkg::SLOT_W-1:0]    load_slot,
    input  cnf_pkg::slot_t                load_entry,
    output cnf_pkg::clause_t              clause_q
);

    cnf_pkg::clause_t clause_reg;
    cnf_pkg::clause_t clause_next;

    always_comb begin
        clause_next = clause_reg;
        if (shift_en) begin
            clause_next = shift_in;
        end else if (load_en) begin
            clause_next[load_slot] = load_entry;
        end
    end

    // present flags are reset: all slots empty
    always_ff @(posedge aclk) begin
        for (int s = 0; s < cnf_pkg::SLOTS_PER_CLAUSE; s++) begin
            if (!aresetn) begin
                clause_reg[s].present <= 1'b0;
            end else begin
                clause_reg[s].present <= clause_next[s].present;
            end
            clause_reg[s].negated <= clause_next[s].negated;
            clause_reg[s].atom    <= clause_next[s].atom;
        end
    end

    assign clause_q = clause_reg;

endmodule

[hdl/cnf_clause_eval.sv]
// Ring-head evaluator: tests one clause per step cycle; accumulates mask and count.
module cnf_clause_eval (
    input  logic                           aclk,
    input  cnf_pkg::eval_ctrl_t            ctrl,
    input  cnf_pkg::clause_t               clause_in,
    input  logic [cnf_pkg::MASK_W-1:0]     assignment,
    output logic [cnf_pkg::MASK_W-1:0]     mask,
    output logic [cnf_pkg::COUNT_W-1:0]    count
);

    logic [cnf_pkg::MASK_W-1:0]  mask_reg;
    logic [cnf_pkg::MASK_W-1:0]  mask_next;
    logic [cnf_pkg::COUNT_W-1:0] count_reg;
    logic [cnf_pkg::COUNT_W-1:0] count_next;
    logic                        is_false;

    assign is_false = ctrl.in_use & ~cnf_pkg::clause_holds(clause_in, assignment);

    always_comb begin
        mask_next  = mask_reg;
        count_next = count_reg;
        if (ctrl.clear) begin
            mask_next  = '0;
            count_next = '0;
        end else if (ctrl.step) begin
            // clause k arrives at step k; after the last step bit k sits at position k
            mask_next  = {is_false, mask_reg[cnf_pkg::MASK_W-1:1]};
            count_next = count_reg + cnf_pkg::COUNT_W'(is_false);
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg  <= mask_next;
        count_reg <= count_next;
    end

    assign mask  = mask_reg;
    assign count = count_reg;

endmodule

[hdl/cnf_formula_evaluator.sv]
// Top level of the CNF formula evaluator: clause ring, evaluator and handshake control.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    request type, load fields, assignment
//  m_       out        m_valid / m_ready    satisfied, false clause mask and count
//  cfg      in         cfg_we               cfg_wdata -> clause count
//
// A load beat writes one slot of one clause. An evaluate beat rotates the 64-clause ring
// once past the evaluator, one clause per cycle, then loads the output register when free.
// s_ready is low while an evaluation runs and while its result waits for a busy output
// register; a held result alone does not block new beats.
// Reset (aresetn low, synchronous) empties every slot and sets the clause count to zero.
module cnf_formula_evaluator (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [cnf_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [cnf_pkg::CIDX_W-1:0]      s_clause_index,
    input  logic [cnf_pkg::SIDX_W-1:0]      s_slot_index,
    input  logic [cnf_pkg::ATOM_W-1:0]      s_literal_atom,
    input  logic                            s_literal_negated,
    input  logic                            s_literal_present,
    input  logic [cnf_pkg::MASK_W-1:0]      s_assignment,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_satisfied,
    output logic [cnf_pkg::MASK_W-1:0]      m_false_clause_mask,
    output logic [cnf_pkg::COUNT_W-1:0]     m_false_clause_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t                        state_reg, state_next;
    logic [cnf_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [cnf_pkg::CFG_W-1:0]     clause_count_reg;
    logic [cnf_pkg::MASK_W-1:0]    assign_reg;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_sat_reg;
    logic [cnf_pkg::MASK_W-1:0]    m_mask_reg;
    logic [cnf_pkg::COUNT_W-1:0]   m_count_reg;

    logic                          accept;
    logic                          load_hit;
    logic                          eval_start;
    logic                          out_free;
    logic                          shift_en;
    logic [cnf_pkg::CFG_W-1:0]     n_eff;
    cnf_pkg::slot_t                load_entry;
    cnf_pkg::eval_ctrl_t           ctrl;
    cnf_pkg::clause_t              cell_q [cnf_pkg::MAX_CLAUSES];
    logic [cnf_pkg::MASK_W-1:0]    acc_mask;
    logic [cnf_pkg::COUNT_W-1:0]   acc_count;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid & s_ready;
    assign eval_start = accept & (s_req_type == cnf_pkg::REQ_EVAL);
    assign load_hit   = accept & (s_req_type == cnf_pkg::REQ_LOAD)
                      & (cnf_pkg::CFG_W'(s_clause_index) < cnf_pkg::CFG_W'(cnf_pkg::MAX_CLAUSES))
                      & (4'(s_slot_index) < 4'(cnf_pkg::SLOTS_PER_CLAUSE));
    assign shift_en   = (state_reg == ST_EVAL);
    assign out_free   = ~m_valid_reg | m_ready;

    assign load_entry.present = s_literal_present;
    assign load_entry.negated = s_literal_negated;
    assign load_entry.atom    = s_literal_atom;

    assign n_eff = (clause_count_reg > cnf_pkg::CFG_W'(cnf_pkg::MAX_CLAUSES))
                 ? cnf_pkg::CFG_W'(cnf_pkg::MAX_CLAUSES) : clause_count_reg;

    assign ctrl.clear  = eval_start;
    assign ctrl.step   = shift_en;
    assign ctrl.in_use = (cnf_pkg::CFG_W'(step_reg) < n_eff);

    // ring: each cell takes its upper neighbor; cell 0 feeds the evaluator
    for (genvar i = 0; i < cnf_pkg::MAX_CLAUSES; i++) begin : g_cell
        cnf_clause_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (shift_en),
            .shift_in   (cell_q[(i + 1) % cnf_pkg::MAX_CLAUSES]),
            .load_en    (load_hit & (s_clause_index == cnf_pkg::CIDX_W'(i))),
            .load_slot  (s_slot_index[cnf_pkg::SLOT_W-1:0]),
            .load_entry (load_entry),
            .clause_q   (cell_q[i])
        );
    end

    cnf_clause_eval u_eval (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .clause_in  (cell_q[0]),
        .assignment (assign_reg),
        .mask       (acc_mask),
        .count      (acc_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clause_count_reg <= '0;
        end else if (cfg_we) begin
            clause_count_reg <= cfg_wdata;
        end
        if (eval_start) begin
            assign_reg <= s_assignment;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (eval_start) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == cnf_pkg::STEP_W'(cnf_pkg::MAX_CLAUSES - 1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
        if (state_reg == ST_FLUSH && out_free) begin
            m_sat_reg   <= (acc_count == '0);
            m_mask_reg  <= acc_mask;
            m_count_reg <= acc_count;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_satisfied          = m_sat_reg;
    assign m_false_clause_mask  = m_mask_reg;
    assign m_false_clause_count = m_count_reg;

endmodule
